/* rtl/core/fdbs_pkg.sv */
// Shared types and constants of the frequency-domain beam summer.
package fdbs_pkg;

    localparam int ACC_W = 36;

    localparam logic CFG_ANTENNA_COUNT = 1'b0;
    localparam logic CFG_PIXEL_COUNT   = 1'b1;

    typedef struct packed {
        logic              func;
        logic [5:0]        freq_bin;
        logic [3:0]        pixel_index;
        logic [3:0]        antenna_index;
        logic signed [15:0] value_re;
        logic signed [15:0] value_im;
    } fdbs_in_t;

    typedef struct packed {
        logic [5:0]         out_freq_bin;
        logic [3:0]         out_pixel;
        logic signed [15:0] beam_re;
        logic signed [15:0] beam_im;
        logic               last;
    } fdbs_out_t;

    typedef struct packed {
        logic capture;
        logic wt_write;
        logic mac_issue;
        logic emit_read;
        logic out_load;
        logic last;
        logic clr_write;
        logic clr_sweep;
    } fdbs_cmd_t;

    typedef struct packed {
        logic bin_ok;
        logic is_sample;
        logic wt_ok;
        logic ant_ok;
        logic completes;
        logic mac_busy;
        logic div_done;
        logic out_free;
    } fdbs_stat_t;

endpackage

/* rtl/core/fdbs_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module fdbs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/core/fdbs_div.sv */
// Bit-serial signed divider: accumulator by antenna count, truncated toward zero.
module fdbs_div
    import fdbs_pkg::*;
#(
    parameter int DIV_W = 5
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic signed [ACC_W-1:0] dividend,
    input  logic [DIV_W-1:0]        divisor,
    output logic                    done,
    output logic signed [ACC_W:0]   quotient
);

    localparam int CNT_W = $clog2(ACC_W);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic             neg_reg, neg_next;
    logic [ACC_W-1:0] quo_reg, quo_next;
    logic [DIV_W-1:0] rem_reg, rem_next;
    logic [DIV_W-1:0] div_reg, div_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_W:0]   trial;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = done_reg;
        neg_next  = neg_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        cnt_next  = cnt_reg;
        trial     = {rem_reg, quo_reg[ACC_W-1]};
        if (start)
        begin
            busy_next = 1'b1;
            done_next = 1'b0;
            neg_next  = dividend[ACC_W-1];
            quo_next  = dividend[ACC_W-1] ? ACC_W'(-dividend) : ACC_W'(dividend);
            rem_next  = '0;
            div_next  = divisor;
            cnt_next  = '0;
        end
        else if (busy_reg)
        begin
            // one quotient bit per cycle, restoring
            if (trial >= {1'b0, div_reg})
            begin
                rem_next = DIV_W'(trial - {1'b0, div_reg});
                quo_next = {quo_reg[ACC_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = DIV_W'(trial);
                quo_next = {quo_reg[ACC_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(ACC_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
        cnt_reg <= cnt_next;
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? -$signed({1'b0, quo_reg}) : $signed({1'b0, quo_reg});

endmodule

/* rtl/core/fdbs_ctrl.sv */
// Sequencer of the beam summer: reset sweep, decode, MAC issue, emit, wipe.
module fdbs_ctrl
    import fdbs_pkg::*;
#(
    parameter int MAX_PIXELS = 16,
    parameter int ACC_DEPTH  = 1024,
    parameter int PIX_W      = 4,
    parameter int PCNT_W     = 5,
    parameter int ACC_AW     = 10
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              sample_valid,
    output logic              sample_stall,
    input  logic [PCNT_W-1:0] npix,
    input  fdbs_stat_t        st,
    output fdbs_cmd_t         cmd,
    output logic [PIX_W-1:0]  pixel,
    output logic [ACC_AW-1:0] sweep_addr
);

    localparam logic [3:0] S_CLEAR    = 4'd0;
    localparam logic [3:0] S_IDLE     = 4'd1;
    localparam logic [3:0] S_DECODE   = 4'd2;
    localparam logic [3:0] S_MAC      = 4'd3;
    localparam logic [3:0] S_DRAIN    = 4'd4;
    localparam logic [3:0] S_EMIT_RD  = 4'd5;
    localparam logic [3:0] S_EMIT_DIV = 4'd6;
    localparam logic [3:0] S_EMIT_OUT = 4'd7;
    localparam logic [3:0] S_WIPE     = 4'd8;

    logic [3:0]        state_reg, state_next;
    logic [PCNT_W-1:0] pix_reg, pix_next;
    logic [ACC_AW-1:0] sweep_reg, sweep_next;
    logic              pix_last;

    assign pix_last = (int'(pix_reg) == int'(npix) - 1);

    always_comb
    begin
        state_next = state_reg;
        pix_next   = pix_reg;
        sweep_next = sweep_reg;
        cmd        = '0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_write = 1'b1;
                cmd.clr_sweep = 1'b1;
                if (sweep_reg == ACC_AW'(ACC_DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    sweep_next = sweep_reg + 1'b1;
                end
            end
            S_IDLE:
            begin
                if (sample_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE:
            begin
                pix_next   = '0;
                state_next = S_IDLE;
                if (st.bin_ok)
                begin
                    if (!st.is_sample)
                    begin
                        cmd.wt_write = st.wt_ok;
                    end
                    else if (st.ant_ok)
                    begin
                        state_next = S_MAC;
                    end
                end
            end
            S_MAC:
            begin
                cmd.mac_issue = 1'b1;
                if (pix_last)
                begin
                    pix_next   = '0;
                    state_next = S_DRAIN;
                end
                else
                begin
                    pix_next = pix_reg + 1'b1;
                end
            end
            S_DRAIN:
            begin
                if (!st.mac_busy)
                begin
                    state_next = st.completes ? S_EMIT_RD : S_IDLE;
                end
            end
            S_EMIT_RD:
            begin
                cmd.emit_read = 1'b1;
                state_next    = S_EMIT_DIV;
            end
            S_EMIT_DIV:
            begin
                if (st.div_done)
                begin
                    state_next = S_EMIT_OUT;
                end
            end
            S_EMIT_OUT:
            begin
                if (st.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.last     = pix_last;
                    if (pix_last)
                    begin
                        pix_next   = '0;
                        state_next = S_WIPE;
                    end
                    else
                    begin
                        pix_next   = pix_reg + 1'b1;
                        state_next = S_EMIT_RD;
                    end
                end
            end
            S_WIPE:
            begin
                // clear every pixel of the bin, not only the active ones
                cmd.clr_write = 1'b1;
                if (pix_reg == PCNT_W'(MAX_PIXELS - 1))
                begin
                    pix_next   = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    pix_next = pix_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            pix_reg   <= '0;
            sweep_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pix_reg   <= pix_next;
            sweep_reg <= sweep_next;
        end
    end

    assign sample_stall = (state_reg != S_IDLE);
    assign pixel        = pix_reg[PIX_W-1:0];
    assign sweep_addr   = sweep_reg;

endmodule

/* rtl/core/fdbs_datapath.sv */
// Beam summer datapath: item and config registers, stores, MAC pipe, dividers, output.
module fdbs_datapath
    import fdbs_pkg::*;
#(
    parameter int FREQ_BINS    = 64,
    parameter int MAX_PIXELS   = 16,
    parameter int MAX_ANTENNAS = 16,
    parameter int PIX_W        = 4,
    parameter int PCNT_W       = 5,
    parameter int ACC_AW       = 10
) (
    input  logic              clk,
    input  logic              rst_n,
    input  fdbs_in_t          sample,
    input  logic              cfg_valid,
    input  logic              cfg_index,
    input  logic [4:0]        cfg_data,
    input  fdbs_cmd_t         cmd,
    input  logic [PIX_W-1:0]  pixel,
    input  logic [ACC_AW-1:0] sweep_addr,
    output fdbs_stat_t        st,
    output logic [PCNT_W-1:0] npix,
    output logic              beam_valid,
    input  logic              beam_stall,
    output fdbs_out_t         beam
);

    localparam int ACC_DEPTH = FREQ_BINS * MAX_PIXELS;
    localparam int W_DEPTH   = ACC_DEPTH * MAX_ANTENNAS;
    localparam int W_AW      = W_DEPTH > 1 ? $clog2(W_DEPTH) : 1;
    localparam int NANT_W    = $clog2(MAX_ANTENNAS + 1);

    fdbs_in_t          item_reg;
    logic [4:0]        cfg_ant_reg, cfg_pix_reg;
    logic [NANT_W-1:0] nant;

    logic [W_AW-1:0]    w_waddr, w_raddr;
    logic [31:0]        w_rdata;
    logic               acc_we;
    logic [ACC_AW-1:0]  acc_waddr, acc_raddr;
    logic [2*ACC_W-1:0] acc_wdata, acc_rdata;

    logic                    rd_v1_reg, s2_v_reg, rd_e1_reg;
    logic [ACC_AW-1:0]       a1_reg, a2_reg;
    logic signed [31:0]      prr_reg, pii_reg, pri_reg, pir_reg;
    logic signed [ACC_W-1:0] acc_re2_reg, acc_im2_reg;
    logic signed [32:0]      sum_re, sum_im;
    logic signed [ACC_W-1:0] new_re, new_im;

    logic                  done_re, done_im;
    logic signed [ACC_W:0] q_re, q_im;

    logic      out_valid_reg, out_valid_next;
    fdbs_out_t out_reg;

    function automatic logic signed [15:0] sat16(input logic signed [ACC_W:0] q);
        logic signed [ACC_W:0] s;
        s = q >>> 15;
        if (s > 32767)
        begin
            return 16'sh7FFF;
        end
        else if (s < -32768)
        begin
            return 16'sh8000;
        end
        return s[15:0];
    endfunction

    // clamp the configured counts to the supported range
    always_comb
    begin
        if (cfg_ant_reg == 5'd0)
        begin
            nant = NANT_W'(1);
        end
        else if (int'(cfg_ant_reg) > MAX_ANTENNAS)
        begin
            nant = NANT_W'(MAX_ANTENNAS);
        end
        else
        begin
            nant = NANT_W'(cfg_ant_reg);
        end
        if (cfg_pix_reg == 5'd0)
        begin
            npix = PCNT_W'(1);
        end
        else if (int'(cfg_pix_reg) > MAX_PIXELS)
        begin
            npix = PCNT_W'(MAX_PIXELS);
        end
        else
        begin
            npix = PCNT_W'(cfg_pix_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_ant_reg <= 5'd16;
            cfg_pix_reg <= 5'd16;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_ANTENNA_COUNT: cfg_ant_reg <= cfg_data;
                CFG_PIXEL_COUNT:   cfg_pix_reg <= cfg_data;
                default:           cfg_ant_reg <= cfg_ant_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            item_reg <= sample;
        end
    end

    // item decode
    assign st.bin_ok    = int'(item_reg.freq_bin) < FREQ_BINS;
    assign st.is_sample = item_reg.func;
    assign st.wt_ok     = (int'(item_reg.pixel_index) < MAX_PIXELS)
                          && (int'(item_reg.antenna_index) < MAX_ANTENNAS);
    assign st.ant_ok    = int'(item_reg.antenna_index) < MAX_ANTENNAS;
    assign st.completes = int'(item_reg.antenna_index) == int'(nant) - 1;
    assign st.mac_busy  = rd_v1_reg || s2_v_reg;
    assign st.div_done  = done_re && done_im && !rd_e1_reg;
    assign st.out_free  = !out_valid_reg || !beam_stall;

    // weight store
    assign w_waddr = W_AW'((int'(item_reg.freq_bin) * MAX_PIXELS
                     + int'(item_reg.pixel_index)) * MAX_ANTENNAS
                     + int'(item_reg.antenna_index));
    assign w_raddr = W_AW'((int'(item_reg.freq_bin) * MAX_PIXELS + int'(pixel))
                     * MAX_ANTENNAS + int'(item_reg.antenna_index));

    fdbs_ram #(
        .WIDTH (32),
        .DEPTH (W_DEPTH)
    ) u_wt_ram (
        .clk   (clk),
        .we    (cmd.wt_write),
        .waddr (w_waddr),
        .wdata ({item_reg.value_im, item_reg.value_re}),
        .raddr (w_raddr),
        .rdata (w_rdata)
    );

    // accumulator store: imaginary in the upper half
    assign acc_raddr = ACC_AW'(int'(item_reg.freq_bin) * MAX_PIXELS + int'(pixel));
    assign sum_re    = 33'(prr_reg) - 33'(pii_reg);
    assign sum_im    = 33'(pri_reg) + 33'(pir_reg);
    assign new_re    = acc_re2_reg + ACC_W'(sum_re);
    assign new_im    = acc_im2_reg + ACC_W'(sum_im);
    assign acc_we    = s2_v_reg || cmd.clr_write;

    always_comb
    begin
        if (cmd.clr_write)
        begin
            acc_waddr = cmd.clr_sweep ? sweep_addr : acc_raddr;
            acc_wdata = '0;
        end
        else
        begin
            acc_waddr = a2_reg;
            acc_wdata = {new_im, new_re};
        end
    end

    fdbs_ram #(
        .WIDTH (2 * ACC_W),
        .DEPTH (ACC_DEPTH)
    ) u_acc_ram (
        .clk   (clk),
        .we    (acc_we),
        .waddr (acc_waddr),
        .wdata (acc_wdata),
        .raddr (acc_raddr),
        .rdata (acc_rdata)
    );

    // MAC pipe: read, multiply, add and write back
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_v1_reg <= 1'b0;
            s2_v_reg  <= 1'b0;
            rd_e1_reg <= 1'b0;
        end
        else
        begin
            rd_v1_reg <= cmd.mac_issue;
            s2_v_reg  <= rd_v1_reg;
            rd_e1_reg <= cmd.emit_read;
        end
    end

    always_ff @(posedge clk)
    begin
        a1_reg      <= acc_raddr;
        a2_reg      <= a1_reg;
        prr_reg     <= item_reg.value_re * $signed(w_rdata[15:0]);
        pii_reg     <= item_reg.value_im * $signed(w_rdata[31:16]);
        pri_reg     <= item_reg.value_re * $signed(w_rdata[31:16]);
        pir_reg     <= item_reg.value_im * $signed(w_rdata[15:0]);
        acc_re2_reg <= $signed(acc_rdata[ACC_W-1:0]);
        acc_im2_reg <= $signed(acc_rdata[2*ACC_W-1:ACC_W]);
    end

    fdbs_div #(
        .DIV_W (NANT_W)
    ) u_div_re (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (rd_e1_reg),
        .dividend ($signed(acc_rdata[ACC_W-1:0])),
        .divisor  (nant),
        .done     (done_re),
        .quotient (q_re)
    );

    fdbs_div #(
        .DIV_W (NANT_W)
    ) u_div_im (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (rd_e1_reg),
        .dividend ($signed(acc_rdata[2*ACC_W-1:ACC_W])),
        .divisor  (nant),
        .done     (done_im),
        .quotient (q_im)
    );

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!beam_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_reg.out_freq_bin <= item_reg.freq_bin;
            out_reg.out_pixel    <= 4'(pixel);
            out_reg.beam_re      <= sat16(q_re);
            out_reg.beam_im      <= sat16(q_im);
            out_reg.last         <= cmd.last;
        end
    end

    assign beam_valid = out_valid_reg;
    assign beam       = out_reg;

endmodule

/* rtl/core/freq_domain_beam_sum_top.sv */
// Top level of the frequency-domain delay-and-sum beamformer.
//
// Weight items (func 0) write one Q1.15 complex weight per bin, pixel and
// antenna; sample items (func 1) multiply one complex spectrum value by the
// weights of all active pixels and add into per-pixel 36-bit accumulators.
// The sample whose antenna is the last one of antenna_count completes its
// bin: the block then emits one item per pixel, sum / antenna_count
// (toward zero) >>> 15, saturated, and clears the bin's accumulators. One
// item is in work at a time. A sample runs through the single-issue MAC
// pipe one pixel per cycle (read / multiply / write back), and a completing
// sample then passes each pixel through the bit-serial divider (one quotient
// bit per cycle over 36 bits) and wipes all MAX_PIXELS pixels of the bin.
// After reset the accumulator memory (FREQ_BINS * MAX_PIXELS words, 1024 by
// default) is cleared before the first item is taken; configuration writes
// are accepted at any time (cfg_ready is tied high) and must only occur
// while the block is idle.
module freq_domain_beam_sum_top
    import fdbs_pkg::*;
#(
    parameter int FREQ_BINS    = 64,
    parameter int MAX_PIXELS   = 16,
    parameter int MAX_ANTENNAS = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       sample_valid,
    output logic       sample_stall,
    input  fdbs_in_t   sample,
    output logic       beam_valid,
    input  logic       beam_stall,
    output fdbs_out_t  beam,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_index,
    input  logic [4:0] cfg_data
);

    localparam int ACC_DEPTH = FREQ_BINS * MAX_PIXELS;
    localparam int ACC_AW    = ACC_DEPTH > 1 ? $clog2(ACC_DEPTH) : 1;
    localparam int PIX_W     = MAX_PIXELS > 1 ? $clog2(MAX_PIXELS) : 1;
    localparam int PCNT_W    = $clog2(MAX_PIXELS + 1);

    fdbs_cmd_t         cmd;
    fdbs_stat_t        st;
    logic [PIX_W-1:0]  pixel;
    logic [ACC_AW-1:0] sweep_addr;
    logic [PCNT_W-1:0] npix;

    // config registers are plain flops: always ready
    assign cfg_ready = 1'b1;

    fdbs_ctrl #(
        .MAX_PIXELS (MAX_PIXELS),
        .ACC_DEPTH  (ACC_DEPTH),
        .PIX_W      (PIX_W),
        .PCNT_W     (PCNT_W),
        .ACC_AW     (ACC_AW)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .npix         (npix),
        .st           (st),
        .cmd          (cmd),
        .pixel        (pixel),
        .sweep_addr   (sweep_addr)
    );

    fdbs_datapath #(
        .FREQ_BINS    (FREQ_BINS),
        .MAX_PIXELS   (MAX_PIXELS),
        .MAX_ANTENNAS (MAX_ANTENNAS),
        .PIX_W        (PIX_W),
        .PCNT_W       (PCNT_W),
        .ACC_AW       (ACC_AW)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .sample     (sample),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .cmd        (cmd),
        .pixel      (pixel),
        .sweep_addr (sweep_addr),
        .st         (st),
        .npix       (npix),
        .beam_valid (beam_valid),
        .beam_stall (beam_stall),
        .beam       (beam)
    );

    // a clear write never collides with a MAC write-back
    a_clr_no_mac: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clr_write |-> !st.mac_busy)
        else $error("accumulator clear during MAC write-back");

    // never overwrite an undelivered result
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> st.out_free)
        else $error("output register overwritten");

    // a result is loaded only from a finished division
    a_load_done: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> st.div_done)
        else $error("output loaded before division finished");

    // a new item is taken only with the MAC pipe empty
    a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (sample_valid && !sample_stall) |-> !st.mac_busy)
        else $error("item accepted while MAC pipe busy");

endmodule
